// ===== hdl/accel_kalman_integrator_assert.svh =====
// ------------------------------------------------------------------------
// accel_kalman_integrator assertion macros
// Short forms for the concurrent checks used on the integrator ports.
// ------------------------------------------------------------------------
`ifndef ACCEL_KALMAN_INTEGRATOR_ASSERT_SVH
`define ACCEL_KALMAN_INTEGRATOR_ASSERT_SVH

// antecedent holds, consequent must hold on the next edge
`define AKI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// antecedent holds, consequent must hold on the same edge
`define AKI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/aki_pkg.sv =====
// ------------------------------------------------------------------------
// aki_pkg
// Shared types, register indexes and fixed point helpers of the integrator.
// ------------------------------------------------------------------------
package aki_pkg;

   // wide signed working value for products, sums and rounding
   localparam int WIDE_W = 68;
   typedef logic signed [WIDE_W-1:0] wide_type;

   // configuration register indexes
   typedef logic [2:0] csr_idx_type;
   localparam csr_idx_type REG_BYTE_ORDER    = 3'd0;
   localparam csr_idx_type REG_OFFSET_X      = 3'd1;
   localparam csr_idx_type REG_OFFSET_Y      = 3'd2;
   localparam csr_idx_type REG_OFFSET_Z      = 3'd3;
   localparam csr_idx_type REG_PROCESS_NOISE = 3'd4;
   localparam csr_idx_type REG_MEASURE_NOISE = 3'd5;

   // zero run counter saturates here
   localparam logic [2:0] ZERO_RUN_MAX = 3'd7;

   localparam wide_type S32_MAX = wide_type'(64'sd2147483647);
   localparam wide_type S32_MIN = wide_type'(-64'sd2147483648);

   // right shift rounding half up
   function automatic wide_type rsr(input wide_type v, input int unsigned s);
      wide_type bias;
      bias = wide_type'(1) <<< (s - 1);
      return (v + bias) >>> s;
   endfunction

   // saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input wide_type v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

endpackage

// ===== hdl/accel_kalman_integrator.sv =====
// ------------------------------------------------------------------------
// accel_kalman_integrator
// Accelerometer calibration, per axis scalar Kalman filter and X motion
// integration on one shared multiplier and one bit serial divider.
// ------------------------------------------------------------------------
// Timing is set by the shared multiplier sequence and the bit serial gain
// division of each axis. A new item is taken only in idle, after the last
// result is registered; the result register lets the next item start while
// a result waits
// reset: synchronous, sets filter state, integrators and configuration registers to their defaults
module accel_kalman_integrator
   import aki_pkg::*;
#(
   parameter int FRAC_BITS      = 16,
   parameter int ZERO_RUN_LIMIT = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_x_low,
   input  logic [7:0]         req_x_high,
   input  logic [7:0]         req_y_low,
   input  logic [7:0]         req_y_high,
   input  logic [7:0]         req_z_low,
   input  logic [7:0]         req_z_high,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_filtered_x,
   output logic signed [31:0] rsp_filtered_y,
   output logic signed [31:0] rsp_filtered_z,
   output logic signed [31:0] rsp_velocity_x,
   output logic signed [31:0] rsp_position_x,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int WSH   = FRAC_BITS + 16;
   localparam int ISH   = FRAC_BITS + 8;
   localparam int QW    = FRAC_BITS + 1;
   localparam int NUM_W = FRAC_BITS + 33;
   localparam int DEN_W = 34;

   // calibration coefficients, sensitivity folded in
   localparam longint CK_XX = ((64'sd6201 <<< WSH) + 64'sd50000000) / 64'sd100000000;
   localparam longint CK_XZ = -(((64'sd273 <<< WSH) + 64'sd50000000) / 64'sd100000000);
   localparam longint CK_YX = ((64'sd117 <<< WSH) + 64'sd50000000) / 64'sd100000000;
   localparam longint CK_YY = ((64'sd5889 <<< WSH) + 64'sd50000000) / 64'sd100000000;
   localparam longint CK_YZ = -(((64'sd78 <<< WSH) + 64'sd50000000) / 64'sd100000000);
   localparam longint CK_ZX = ((64'sd273 <<< WSH) + 64'sd50000000) / 64'sd100000000;
   localparam longint CK_ZY = -(((64'sd39 <<< WSH) + 64'sd50000000) / 64'sd100000000);
   localparam longint CK_ZZ = ((64'sd5889 <<< WSH) + 64'sd50000000) / 64'sd100000000;
   localparam longint CC_X  = ((64'sd655 <<< WSH) + 64'sd5000) / 64'sd10000;
   localparam longint CC_Y  = -(((64'sd217 <<< WSH) + 64'sd5000) / 64'sd10000);
   localparam longint CC_Z  = ((64'sd127 <<< WSH) + 64'sd5000) / 64'sd10000;
   localparam longint C98   = ((64'sd98 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
   localparam longint DZ_HI = ((64'sd5 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
   localparam longint DZ_LO = -(((64'sd7 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
   localparam longint C01   = ((64'sd1 <<< ISH) + 64'sd50) / 64'sd100;
   localparam longint C5    = ((64'sd5 <<< ISH) + 64'sd50000) / 64'sd100000;
   localparam logic [QW-1:0]     K_ONE   = QW'(1) << FRAC_BITS;
   localparam logic signed [31:0] EST_Z_RST = 32'(C98);
   localparam logic signed [31:0] COV_RST   = 32'(64'sd1 <<< FRAC_BITS);

   // sequencer states
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CAL_MUL  = 5'd1;
   localparam logic [4:0] S_CAL_ACC  = 5'd2;
   localparam logic [4:0] S_COND_MUL = 5'd3;
   localparam logic [4:0] S_COND_ACC = 5'd4;
   localparam logic [4:0] S_K_PREP   = 5'd5;
   localparam logic [4:0] S_K_DIVGO  = 5'd6;
   localparam logic [4:0] S_K_DIV    = 5'd7;
   localparam logic [4:0] S_K_MUL1   = 5'd8;
   localparam logic [4:0] S_K_UPD1   = 5'd9;
   localparam logic [4:0] S_K_MUL2   = 5'd10;
   localparam logic [4:0] S_K_UPD2   = 5'd11;
   localparam logic [4:0] S_I_MUL1   = 5'd12;
   localparam logic [4:0] S_I_ACC1   = 5'd13;
   localparam logic [4:0] S_I_MUL2   = 5'd14;
   localparam logic [4:0] S_I_ACC2   = 5'd15;
   localparam logic [4:0] S_I_MUL3   = 5'd16;
   localparam logic [4:0] S_I_ACC3   = 5'd17;
   localparam logic [4:0] S_DONE     = 5'd18;

   // configuration
   logic               byte_order_ff, byte_order_in;
   logic signed [31:0] offset_ff [3];
   logic signed [31:0] offset_in [3];
   logic [7:0]         q_noise_ff, q_noise_in;
   logic [7:0]         r_noise_ff, r_noise_in;

   // filter and integrator state
   logic signed [31:0] est_ff [3];
   logic signed [31:0] est_in [3];
   logic signed [31:0] cov_ff [3];
   logic signed [31:0] cov_in [3];
   logic signed [31:0] vel_ff, vel_in;
   logic signed [31:0] pos_ff, pos_in;
   logic [2:0]         zrun_ff, zrun_in;

   // sequencer and work registers
   logic [4:0]         state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic [1:0]         term_ff, term_in;
   logic signed [15:0] raw_ff [3];
   logic signed [15:0] raw_in [3];
   logic signed [65:0] acc_ff, acc_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [31:0] meas_ff, meas_in;
   logic [30:0]        pu_ff, pu_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic               den_pos_ff, den_pos_in;
   logic [QW-1:0]      k_ff, k_in;
   logic signed [31:0] fx_ff, fx_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_fx_ff, out_fx_in;
   logic signed [31:0] out_fy_ff, out_fy_in;
   logic signed [31:0] out_fz_ff, out_fz_in;
   logic signed [31:0] out_vel_ff, out_vel_in;
   logic signed [31:0] out_pos_ff, out_pos_in;

   // shared datapath signals
   logic signed [32:0] mul_a, mul_b;
   logic signed [31:0] cal32, dif32, pu_w, v_new;
   wide_type           den_w;
   logic [NUM_W-1:0]   div_num;
   logic               div_start, div_done;
   logic [QW-1:0]      div_quot;
   logic [2:0]         zrun_nx;
   logic               req_take;

   function automatic logic signed [15:0] build_raw(input logic [7:0] first,
                                                    input logic [7:0] second,
                                                    input logic       big);
      return big ? $signed({first, second}) : $signed({second, first});
   endfunction

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // gain divider
   assign div_num = (NUM_W'(pu_ff) << FRAC_BITS) + NUM_W'(den_ff >> 1);

   aki_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .QUOT_W (QW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // conditioning of the accumulated calibration sum
   assign cal32 = sat32(rsr(wide_type'(acc_ff), 16));
   assign dif32 = sat32(wide_type'(cal32) - wide_type'(offset_ff[axis_ff]));

   // covariance prediction and gain denominator
   assign pu_w  = sat32(wide_type'(cov_ff[axis_ff])
                        + (wide_type'($signed({1'b0, q_noise_ff})) <<< FRAC_BITS));
   assign den_w = wide_type'(pu_w)
                  + (wide_type'($signed({1'b0, r_noise_ff})) <<< FRAC_BITS);

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_CAL_MUL: begin
            mul_a = 33'(raw_ff[term_ff]);
            case ({axis_ff, term_ff})
               4'b0000: mul_b = 33'(CK_XX);
               4'b0010: mul_b = 33'(CK_XZ);
               4'b0100: mul_b = 33'(CK_YX);
               4'b0101: mul_b = 33'(CK_YY);
               4'b0110: mul_b = 33'(CK_YZ);
               4'b1000: mul_b = 33'(CK_ZX);
               4'b1001: mul_b = 33'(CK_ZY);
               4'b1010: mul_b = 33'(CK_ZZ);
               default: mul_b = '0;
            endcase
         end
         S_COND_MUL: begin
            mul_a = 33'(dif32);
            mul_b = 33'(C98);
         end
         S_K_MUL1: begin
            mul_a = 33'($signed({1'b0, k_ff}));
            mul_b = 33'(meas_ff) - 33'(est_ff[axis_ff]);
         end
         S_K_MUL2: begin
            mul_a = 33'($signed({1'b0, K_ONE - k_ff}));
            mul_b = 33'($signed({1'b0, pu_ff}));
         end
         S_I_MUL1: begin
            mul_a = 33'(vel_ff);
            mul_b = 33'(C01);
         end
         S_I_MUL2: begin
            mul_a = 33'(fx_ff);
            mul_b = 33'(C5);
         end
         S_I_MUL3: begin
            mul_a = 33'(fx_ff);
            mul_b = 33'(C01);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign v_new   = sat32(wide_type'(vel_ff) + rsr(wide_type'(prod_ff), ISH));
   assign zrun_nx = (fx_ff == 32'sd0) ?
                    ((zrun_ff == ZERO_RUN_MAX) ? ZERO_RUN_MAX : zrun_ff + 3'd1) : 3'd0;

   // sequencer and state updates
   always_comb begin
      byte_order_in = byte_order_ff;
      offset_in     = offset_ff;
      q_noise_in    = q_noise_ff;
      r_noise_in    = r_noise_ff;
      est_in        = est_ff;
      cov_in        = cov_ff;
      vel_in        = vel_ff;
      pos_in        = pos_ff;
      zrun_in       = zrun_ff;
      state_in      = state_ff;
      axis_in       = axis_ff;
      term_in       = term_ff;
      raw_in        = raw_ff;
      acc_in        = acc_ff;
      meas_in       = meas_ff;
      pu_in         = pu_ff;
      den_in        = den_ff;
      den_pos_in    = den_pos_ff;
      k_in          = k_ff;
      fx_in         = fx_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_fx_in     = out_fx_ff;
      out_fy_in     = out_fy_ff;
      out_fz_in     = out_fz_ff;
      out_vel_in    = out_vel_ff;
      out_pos_in    = out_pos_ff;
      div_start     = 1'b0;

      // register writes
      if (csr_write_en) begin
         case (csr_index)
            REG_BYTE_ORDER:    byte_order_in = csr_wdata[0];
            REG_OFFSET_X:      offset_in[0]  = $signed(csr_wdata);
            REG_OFFSET_Y:      offset_in[1]  = $signed(csr_wdata);
            REG_OFFSET_Z:      offset_in[2]  = $signed(csr_wdata);
            REG_PROCESS_NOISE: q_noise_in    = csr_wdata[7:0];
            REG_MEASURE_NOISE: r_noise_in    = csr_wdata[7:0];
            default: ;
         endcase
      end

      // result handshake
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               raw_in[0] = build_raw(req_x_low, req_x_high, byte_order_ff);
               raw_in[1] = build_raw(req_y_low, req_y_high, byte_order_ff);
               raw_in[2] = build_raw(req_z_low, req_z_high, byte_order_ff);
               axis_in   = 2'd0;
               term_in   = 2'd0;
               acc_in    = 66'(CC_X);
               state_in  = S_CAL_MUL;
            end
         end
         S_CAL_MUL: state_in = S_CAL_ACC;
         S_CAL_ACC: begin
            acc_in = acc_ff + prod_ff;
            if (term_ff == 2'd2) begin
               state_in = S_COND_MUL;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = S_CAL_MUL;
            end
         end
         S_COND_MUL: state_in = S_COND_ACC;
         S_COND_ACC: begin
            meas_in  = sat32(rsr(wide_type'(prod_ff), FRAC_BITS));
            state_in = S_K_PREP;
         end
         S_K_PREP: begin
            pu_in      = pu_w[31] ? '0 : pu_w[30:0];
            den_in     = den_w[DEN_W-1:0];
            den_pos_in = (den_w > wide_type'(0));
            state_in   = S_K_DIVGO;
         end
         S_K_DIVGO: begin
            if (den_pos_ff) begin
               div_start = 1'b1;
               state_in  = S_K_DIV;
            end else begin
               k_in     = '0;
               state_in = S_K_MUL1;
            end
         end
         S_K_DIV: begin
            if (div_done) begin
               k_in     = (div_quot > K_ONE) ? K_ONE : div_quot;
               state_in = S_K_MUL1;
            end
         end
         S_K_MUL1: state_in = S_K_UPD1;
         S_K_UPD1: begin
            est_in[axis_ff] = sat32(wide_type'(est_ff[axis_ff])
                                    + rsr(wide_type'(prod_ff), FRAC_BITS));
            state_in = S_K_MUL2;
         end
         S_K_MUL2: state_in = S_K_UPD2;
         S_K_UPD2: begin
            cov_in[axis_ff] = sat32(rsr(wide_type'(prod_ff), FRAC_BITS));
            term_in = 2'd0;
            case (axis_ff)
               2'd0: begin
                  // dead zone on X zeroes the output, the filter keeps its estimate
                  if (est_ff[0] < 32'(DZ_HI) && est_ff[0] > 32'(DZ_LO)) begin
                     fx_in = '0;
                  end else begin
                     fx_in = est_ff[0];
                  end
                  axis_in  = 2'd1;
                  acc_in   = 66'(CC_Y);
                  state_in = S_CAL_MUL;
               end
               2'd1: begin
                  axis_in  = 2'd2;
                  acc_in   = 66'(CC_Z);
                  state_in = S_CAL_MUL;
               end
               default: state_in = S_I_MUL1;
            endcase
         end
         S_I_MUL1: state_in = S_I_ACC1;
         S_I_ACC1: begin
            acc_in   = prod_ff;
            state_in = S_I_MUL2;
         end
         S_I_MUL2: state_in = S_I_ACC2;
         S_I_ACC2: begin
            pos_in = sat32(wide_type'(pos_ff)
                           + rsr(wide_type'(acc_ff) + wide_type'(prod_ff), ISH));
            state_in = S_I_MUL3;
         end
         S_I_MUL3: state_in = S_I_ACC3;
         S_I_ACC3: begin
            zrun_in  = zrun_nx;
            vel_in   = (zrun_nx > 3'(ZERO_RUN_LIMIT)) ? 32'sd0 : v_new;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_fx_in    = fx_ff;
               out_fy_in    = est_ff[1];
               out_fz_in    = est_ff[2];
               out_vel_in   = vel_ff;
               out_pos_in   = pos_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_ff <= 1'b0;
         offset_ff     <= '{default: 32'sd0};
         q_noise_ff    <= 8'd1;
         r_noise_ff    <= 8'd100;
         est_ff        <= '{32'sd0, 32'sd0, EST_Z_RST};
         cov_ff        <= '{default: COV_RST};
         vel_ff        <= '0;
         pos_ff        <= '0;
         zrun_ff       <= '0;
         state_ff      <= S_IDLE;
         axis_ff       <= '0;
         term_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_order_ff <= byte_order_in;
         offset_ff     <= offset_in;
         q_noise_ff    <= q_noise_in;
         r_noise_ff    <= r_noise_in;
         est_ff        <= est_in;
         cov_ff        <= cov_in;
         vel_ff        <= vel_in;
         pos_ff        <= pos_in;
         zrun_ff       <= zrun_in;
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         term_ff       <= term_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      raw_ff     <= raw_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      meas_ff    <= meas_in;
      pu_ff      <= pu_in;
      den_ff     <= den_in;
      den_pos_ff <= den_pos_in;
      k_ff       <= k_in;
      fx_ff      <= fx_in;
      out_fx_ff  <= out_fx_in;
      out_fy_ff  <= out_fy_in;
      out_fz_ff  <= out_fz_in;
      out_vel_ff <= out_vel_in;
      out_pos_ff <= out_pos_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered_x = out_fx_ff;
   assign rsp_filtered_y = out_fy_ff;
   assign rsp_filtered_z = out_fz_ff;
   assign rsp_velocity_x = out_vel_ff;
   assign rsp_position_x = out_pos_ff;

endmodule

// ===== hdl/aki_div.sv =====
// ------------------------------------------------------------------------
// aki_div
// Restoring divider, one quotient bit per cycle. The caller keeps the
// numerator's upper part below the denominator and holds den stable.
// ------------------------------------------------------------------------
module aki_div #(
   parameter int NUM_W  = 49,
   parameter int DEN_W  = 34,
   parameter int QUOT_W = 17
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [DEN_W:0]    trial;
   logic              ge;

   // one trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff, q_ff[QUOT_W-1]};
      ge      = (trial >= {1'b0, den});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = DEN_W'(num[NUM_W-1:QUOT_W]);
         q_in    = num[QUOT_W-1:0];
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
         q_in   = {q_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== hdl/aki_checker.sv =====
// ------------------------------------------------------------------------
// aki_checker
// Port level checks of the integrator, bound to the top level.
// ------------------------------------------------------------------------
`include "accel_kalman_integrator_assert.svh"

module aki_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_filtered_x,
   input logic [31:0] rsp_filtered_y,
   input logic [31:0] rsp_filtered_z,
   input logic [31:0] rsp_velocity_x,
   input logic [31:0] rsp_position_x
);

   // a held result stays offered
   `AKI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   // a held result keeps its payload
   `AKI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_filtered_x) && $stable(rsp_filtered_y) && $stable(rsp_filtered_z) && $stable(rsp_velocity_x) && $stable(rsp_position_x), "result changed while stalled")

   // an accepted item keeps the block busy
   `AKI_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall, "input not blocked after item")

   // a fresh result appears only as the sequencer goes idle
   `AKI_ASSERT_SAME(a_rsp_when_idle, clock, reset, $rose(rsp_valid), !req_stall, "result raised while busy")

endmodule

bind accel_kalman_integrator aki_checker u_aki_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_filtered_x (rsp_filtered_x),
   .rsp_filtered_y (rsp_filtered_y),
   .rsp_filtered_z (rsp_filtered_z),
   .rsp_velocity_x (rsp_velocity_x),
   .rsp_position_x (rsp_position_x)
);
